[src/sorted_index_range_leb128_encoder_top_macros.svh]
// Assertion macros for the run-range LEB128 encoder.
// Used by sorted_index_range_leb128_encoder_top; no other dependencies.
`ifndef SORTED_INDEX_RANGE_LEB128_ENCODER_TOP_MACROS_SVH
`define SORTED_INDEX_RANGE_LEB128_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SIRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SIRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[src/sirl_pkg.sv]
// Shared types and constants for the run-range LEB128 encoder.
// No dependencies; used by every module in src.
package sirl_pkg;

	localparam int unsigned IDX_W     = 32;
	localparam int unsigned LEB_DIGIT = 7;
	localparam logic [6:0]  LEB_MASK  = 7'h7F;
	localparam logic        LEB_MORE  = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] index_value;
		logic             list_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       item_done;
		logic       stream_done;
	} out_item_t;

	// Work handed from the run tracker to the serialiser
	typedef struct packed {
		logic       valid;
		logic [2:0] count;
		logic       last;
	} job_ctl_t;

endpackage

[src/sirl_run.sv]
// Run tracker: holds the open run and decides which values an item emits.
// Depends on sirl_pkg.
module sirl_run #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  sirl_pkg::in_item_t            item,
	output sirl_pkg::job_ctl_t            ctl,
	output logic [3:0][VALUE_WIDTH-1:0]   vals
);

	logic                   open_q;
	logic [VALUE_WIDTH-1:0] first_q;
	logic [VALUE_WIDTH-1:0] extra_q;
	logic [VALUE_WIDTH-1:0] next_q;

	logic                   ext;
	logic                   closed;
	logic [VALUE_WIDTH-1:0] v;
	logic [VALUE_WIDTH-1:0] extra_inc;
	logic [VALUE_WIDTH-1:0] b_first;
	logic [VALUE_WIDTH-1:0] b_extra;

	assign v         = VALUE_WIDTH'(item.index_value);
	assign ext       = open_q && (v == next_q);
	assign closed    = open_q && !ext;
	assign extra_inc = extra_q + VALUE_WIDTH'(1);

	// final run on list end: the extended run, or the new one-index run
	assign b_first = ext ? first_q : v;
	assign b_extra = ext ? extra_inc : '0;

	always_comb begin
		if (closed) begin
			vals[0] = first_q;
			vals[1] = extra_q;
		end else begin
			vals[0] = b_first;
			vals[1] = b_extra;
		end
		vals[2]   = b_first;
		vals[3]   = b_extra;
		ctl.valid = accept;
		ctl.last  = item.list_end;
		ctl.count = (closed ? 3'd2 : 3'd0) + (item.list_end ? 3'd2 : 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			first_q <= '0;
			extra_q <= '0;
			next_q  <= '0;
		end else if (accept) begin
			if (ext) begin
				extra_q <= extra_inc;
				next_q  <= next_q + VALUE_WIDTH'(1);
			end else begin
				first_q <= v;
				extra_q <= '0;
				next_q  <= v + VALUE_WIDTH'(1);
			end
			open_q <= !item.list_end;
		end
	end

endmodule

[src/sirl_leb.sv]
// LEB128 serialiser: shifts each value out seven bits per cycle into an
// output register while rsp_ready does not stall it. Depends on sirl_pkg.
module sirl_leb #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sirl_pkg::job_ctl_t          ctl,
	input  logic [3:0][VALUE_WIDTH-1:0] vals,
	output logic                        busy,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output sirl_pkg::out_item_t         rsp_item
);

	logic [2:0][VALUE_WIDTH-1:0] q_q;
	logic [VALUE_WIDTH-1:0]      sh_q;
	logic [1:0]                  left_q;
	logic                        act_q;
	logic                        last_q;
	logic                        out_valid_q;
	sirl_pkg::out_item_t         out_q;

	logic                   can_emit;
	logic                   more;
	logic [VALUE_WIDTH-1:0] sh_next;
	logic                   fin;

	assign can_emit  = !out_valid_q || rsp_ready;
	assign sh_next   = sh_q >> sirl_pkg::LEB_DIGIT;
	assign more      = |sh_next;
	assign fin       = !more && (left_q == 2'd0);
	assign busy      = act_q;
	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	always_ff @(posedge clk) begin
		if (ctl.valid && (ctl.count != 3'd0)) begin
			sh_q   <= vals[0];
			q_q[0] <= vals[1];
			q_q[1] <= vals[2];
			q_q[2] <= vals[3];
		end else if (act_q && can_emit) begin
			if (more) begin
				sh_q <= sh_next;
			end else begin
				// advance to the next queued value
				sh_q   <= q_q[0];
				q_q[0] <= q_q[1];
				q_q[1] <= q_q[2];
			end
		end
		if (act_q && can_emit) begin
			out_q.out_byte    <= {more ? sirl_pkg::LEB_MORE : 1'b0,
				sh_q[6:0] & sirl_pkg::LEB_MASK};
			out_q.item_done   <= fin;
			out_q.stream_done <= fin && last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			left_q      <= 2'd0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.valid && (ctl.count != 3'd0)) begin
				act_q  <= 1'b1;
				left_q <= 2'(ctl.count - 3'd1);
				last_q <= ctl.last;
			end else if (act_q && can_emit) begin
				if (!more) begin
					if (left_q == 2'd0) begin
						act_q <= 1'b0;
					end else begin
						left_q <= left_q - 2'd1;
					end
				end
			end
			if (act_q && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				// drop the item once taken
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/sorted_index_range_leb128_encoder_top.sv]
// Top level of the run-range LEB128 encoder; instantiates sirl_run and
// sirl_leb, uses sirl_pkg and the assertion macro header.
`include "sorted_index_range_leb128_encoder_top_macros.svh"

// Index items arrive sorted, one per handshake. An index that extends the
// open run with list_end clear is accepted without lowering req_ready and
// produces nothing. An index that breaks the run, or one with list_end set,
// produces the LEB128 bytes of the run's start and extra count (and of the
// final run on list end), one byte per cycle unless rsp_ready stalls the
// output, from a shift register that drops seven bits per byte: up to
// ceil(VALUE_WIDTH/7) bytes per value, up to four values per item, 20 bytes
// at the default width. The block holds req_ready low while it serialises,
// also while rsp_ready is low with a byte waiting, and takes the next item
// the cycle after the last byte has entered the output register.
module sorted_index_range_leb128_encoder_top #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sirl_pkg::in_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output sirl_pkg::out_item_t rsp_item
);

	sirl_pkg::job_ctl_t          ctl;
	logic [3:0][VALUE_WIDTH-1:0] vals;
	logic                        busy;
	logic                        accept;

	assign req_ready = !busy;
	assign accept    = req_valid && req_ready;

	sirl_run #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_run (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (req_item),
		.ctl   (ctl),
		.vals  (vals)
	);

	sirl_leb #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_leb (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.vals     (vals),
		.busy     (busy),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item (rsp_item)
	);

	`SIRL_ASSERT_NOW(a_stream_on_item, clk, arst_n,
		rsp_valid && rsp_item.stream_done, rsp_item.item_done)
	`SIRL_ASSERT_NOW(a_cont_not_done, clk, arst_n,
		rsp_valid && rsp_item.out_byte[7], !rsp_item.item_done)
	`SIRL_ASSERT_NEXT(a_end_goes_busy, clk, arst_n,
		accept && req_item.list_end, !req_ready)

endmodule

[tb/tb_sorted_index_range_leb128_encoder_top.sv]
// Testbench for sorted_index_range_leb128_encoder_top: drives index lists, predicts the
// LEB128 run bytes in-bench and checks every output byte in order.
// Depends on sirl_pkg and the RTL under src only.
module tb_sorted_index_range_leb128_encoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned SHOWN_MAX = 10;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	sirl_pkg::in_item_t  req_item;
	logic                rsp_valid;
	logic                rsp_ready;
	sirl_pkg::out_item_t rsp_item;

	// Predictor state: the run currently open
	logic        open_run;
	logic [31:0] run_start;
	logic [31:0] run_count;

	sirl_pkg::out_item_t expected_bytes[$];
	int unsigned         mismatches;
	int unsigned         items_sent;
	int unsigned         hold_cycles;
	bit                  src_idle_on;
	bit                  sink_idle_on;

	sorted_index_range_leb128_encoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item (rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_leb(input logic [31:0] value);
		logic [31:0]         rest;
		sirl_pkg::out_item_t b;
		rest = value;
		do begin
			b = '0;
			b.out_byte = {1'b0, sirl_pkg::LEB_MASK & rest[sirl_pkg::LEB_DIGIT-1:0]};
			rest = rest >> sirl_pkg::LEB_DIGIT;
			if (rest != 0)
				b.out_byte[7] = sirl_pkg::LEB_MORE;
			expected_bytes.push_back(b);
		end while (rest != 0);
	endtask

	// Work out the bytes one accepted index causes and queue them
	task automatic encode_index(input sirl_pkg::in_item_t it);
		int unsigned         before_cnt;
		sirl_pkg::out_item_t tail;
		before_cnt = expected_bytes.size();
		if (open_run && it.index_value == run_start + run_count + 32'd1) begin
			run_count = run_count + 32'd1;
		end else begin
			if (open_run) begin
				push_leb(run_start);
				push_leb(run_count);
			end
			run_start = it.index_value;
			run_count = '0;
			open_run = 1'b1;
		end
		if (it.list_end) begin
			push_leb(run_start);
			push_leb(run_count);
			open_run = 1'b0;
		end
		if (expected_bytes.size() > before_cnt) begin
			tail = expected_bytes.pop_back();
			tail.item_done = 1'b1;
			tail.stream_done = it.list_end;
			expected_bytes.push_back(tail);
		end
	endtask

	task automatic send_index(input logic [31:0] value, input logic last);
		sirl_pkg::in_item_t it;
		int unsigned        gap;
		it.index_value = value;
		it.list_end = last;
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (!req_ready);
		encode_index(it);
		items_sent++;
	endtask

	task automatic pause_sender();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_index();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 300);
			1:       return $urandom_range(0, 20000);
			2:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
			default: return $urandom();
		endcase
	endfunction

	// Mostly extend the run; sometimes repeat, jump a little or jump far
	function automatic logic [31:0] next_index(input logic [31:0] prev);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return prev + 32'd1;
		else if (roll < 73)
			return prev;
		else if (roll < 93)
			return prev + 32'd2 + $urandom_range(0, 300);
		else
			return prev + ($urandom() >> $urandom_range(0, 31));
	endfunction

	task automatic send_random_list(input int unsigned len);
		logic [31:0] value;
		value = pick_index();
		for (int unsigned k = 1; k <= len; k++) begin
			send_index(value, k == len);
			value = next_index(value);
		end
	endtask

	task automatic test_directed();
		send_index(32'd0, 1'b1);
		send_index(32'hFFFF_FFFF, 1'b1);
		send_index(32'd127, 1'b1);
		send_index(32'd128, 1'b1);
		// plain run of three
		send_index(32'd5, 1'b0);
		send_index(32'd6, 1'b0);
		send_index(32'd7, 1'b1);
		// break on the last item
		send_index(32'd10, 1'b0);
		send_index(32'd20, 1'b1);
		// run extends across the wrap to zero
		send_index(32'hFFFF_FFFF, 1'b0);
		send_index(32'd0, 1'b1);
		// descending value and a repeat
		send_index(32'd100, 1'b0);
		send_index(32'd50, 1'b0);
		send_index(32'd50, 1'b1);
		send_index(32'hF000_0000, 1'b0);
		send_index(32'hF000_0001, 1'b0);
		send_index(32'hFFFF_FFFF, 1'b1);
		send_index(32'd16383, 1'b0);
		send_index(32'd16384, 1'b0);
		send_index(32'd2097151, 1'b1);
		send_index(32'h8000_0000, 1'b0);
		send_index(32'h0FFF_FFFF, 1'b1);
		pause_sender();
		wait_drained();
	endtask

	task automatic test_random_lists();
		int unsigned first_item;
		first_item = items_sent;
		while (items_sent - first_item < 300) begin
			src_idle_on = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			// one pick in ten sends a loose item outside any well-formed list
			if ($urandom_range(0, 9) == 0)
				send_index($urandom(), 1'($urandom_range(0, 1)));
			else
				send_random_list($urandom_range(1, 14));
		end
		pause_sender();
		wait_drained();
	endtask

	// Hold the output off while items keep coming, so the block backs up
	task automatic test_backpressure();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_cycles = 150;
		for (int unsigned k = 0; k < 16; k++)
			send_index(32'd1000 * k + $urandom_range(0, 999) << (k % 17), k == 15);
		pause_sender();
		wait_drained();
	endtask

	task automatic test_steady_stream();
		int unsigned first_item;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		first_item = items_sent;
		while (items_sent - first_item < 40)
			send_random_list($urandom_range(1, 10));
	endtask

	// Output side: random stall bursts, or a long hold when asked
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sirl_pkg::out_item_t want;
		bit                  stray;
		if (arst_n && rsp_valid && rsp_ready) begin
			stray = expected_bytes.size() == 0;
			want = '0;
			if (!stray)
				want = expected_bytes.pop_front();
			if (stray || rsp_item.out_byte !== want.out_byte
					|| rsp_item.item_done !== want.item_done
					|| rsp_item.stream_done !== want.stream_done) begin
				if (mismatches < SHOWN_MAX) begin
					if (stray)
						$display({"%0t: byte with nothing expected: ",
							"got byte=%02h item_done=%0b stream_done=%0b"},
							$realtime, rsp_item.out_byte, rsp_item.item_done,
							rsp_item.stream_done);
					else
						$display({"%0t: byte mismatch: ",
							"expected byte=%02h item_done=%0b stream_done=%0b, ",
							"got byte=%02h item_done=%0b stream_done=%0b"},
							$realtime, want.out_byte, want.item_done, want.stream_done,
							rsp_item.out_byte, rsp_item.item_done, rsp_item.stream_done);
				end
				mismatches++;
			end
		end
	end

	// Abort if no item moves on either side for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d bytes outstanding",
					$realtime, quiet, expected_bytes.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		open_run = 1'b0;
		run_start = '0;
		run_count = '0;
		mismatches = 0;
		items_sent = 0;
		hold_cycles = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_lists();
		test_backpressure();
		test_steady_stream();
		pause_sender();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
